// File: sv/glp_pkg.sv
// ----------------------------------------------------------------------------
// glp_pkg: shared types and constants for the G-code line parser
// Character codes, token target and number phase codes, decimal scale table.
// ----------------------------------------------------------------------------
`default_nettype none

package glp_pkg;

	// default width of the stored parameter values
	localparam int VALUE_WIDTH = 32;
	// decimal fraction digits kept (0..6)
	localparam int FRACTION_DIGITS = 3;

	// character codes
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// command code match progress; 0..4 are the matched codes
	localparam logic [2:0] MATCH_BAD = 3'd5;
	localparam logic [2:0] MATCH_G   = 3'd6;

	// parameter token targets
	localparam logic [2:0] TGT_NONE = 3'd0;
	localparam logic [2:0] TGT_X    = 3'd1;
	localparam logic [2:0] TGT_Y    = 3'd2;
	localparam logic [2:0] TGT_Z    = 3'd3;
	localparam logic [2:0] TGT_E    = 3'd4;
	localparam logic [2:0] TGT_F    = 3'd5;

	localparam int NUM_VALUES = 5;

	// number conversion phase
	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_INT   = 2'd1,
		PH_FRAC  = 2'd2,
		PH_STOP  = 2'd3
	} phase_t;

	// one character word as held in the input register
	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_line;
	} item_t;

	// 10^k for k = 0..6
	function automatic logic [19:0] pow10(input logic [2:0] k);
		logic [19:0] p;
		case (k)
			3'd0: p = 20'd1;
			3'd1: p = 20'd10;
			3'd2: p = 20'd100;
			3'd3: p = 20'd1000;
			3'd4: p = 20'd10000;
			3'd5: p = 20'd100000;
			3'd6: p = 20'd1000000;
			default: p = 20'd0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// File: sv/glp_char_if.sv
// ----------------------------------------------------------------------------
// glp_char_if: character input channel
// One character word per handshake, with its end-of-line mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface glp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_line;

	modport source (output valid, output char_byte, output end_of_line, input ready);
	modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface

`default_nettype wire

// File: sv/glp_result_if.sv
// ----------------------------------------------------------------------------
// glp_result_if: parsed line result channel
// Stored command code, line valid flag and the five modal parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

interface glp_result_if #(
	parameter int VALUE_WIDTH = glp_pkg::VALUE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic [2:0]                    command_code;
	logic                          command_valid;
	logic signed [VALUE_WIDTH-1:0] x_value;
	logic signed [VALUE_WIDTH-1:0] y_value;
	logic signed [VALUE_WIDTH-1:0] z_value;
	logic signed [VALUE_WIDTH-1:0] e_value;
	logic signed [VALUE_WIDTH-1:0] feed_value;

	modport source (output valid, output command_code, output command_valid,
		output x_value, output y_value, output z_value, output e_value,
		output feed_value, input ready);
	modport sink (input valid, input command_code, input command_valid,
		input x_value, input y_value, input z_value, input e_value,
		input feed_value, output ready);
endinterface

`default_nettype wire

// File: sv/gcode_line_parser.sv
// ----------------------------------------------------------------------------
// gcode_line_parser: G-code command line parser, one character per word
// Takes one character word per cycle. Tokens split at space, CR and LF; the
// first token must start with G (G0..G4 give codes 0..4, any other G token
// gives 5), later X, Y, Z, E and F tokens load signed decimals scaled by
// 10^FRACTION_DIGITS with truncation of extra fraction digits and saturation.
// Code and values are modal across lines. The word marked end_of_line yields
// exactly one result word; all other words yield none. Throughput is one
// character per cycle, set by the character update in glp_core, while no
// line-end word is held back; a result word is registered after its
// end-of-line word leaves the input register. A waiting result stalls only a
// further end-of-line word, never ordinary characters.
// ----------------------------------------------------------------------------
`default_nettype none

module gcode_line_parser #(
	parameter int VALUE_WIDTH = glp_pkg::VALUE_WIDTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	glp_char_if.sink     chars,
	glp_result_if.source result
);

	logic                   valid_s1;
	glp_pkg::item_t         item_s1;
	logic                   advance;
	logic [2:0]             code_n;
	logic                   cmd_valid_n;
	logic [VALUE_WIDTH-1:0] vals_n [glp_pkg::NUM_VALUES];
	logic                   res_valid_q;

	// held word moves into the core unless it closes a line and the result
	// register is still occupied
	assign advance = valid_s1 && (!item_s1.end_of_line || !res_valid_q || result.ready);

	glp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.take     (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	glp_core #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.code_n      (code_n),
		.cmd_valid_n (cmd_valid_n),
		.vals_n      (vals_n)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.end_of_line) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.end_of_line) begin
			result.command_code  <= code_n;
			result.command_valid <= cmd_valid_n;
			result.x_value       <= vals_n[0];
			result.y_value       <= vals_n[1];
			result.z_value       <= vals_n[2];
			result.e_value       <= vals_n[3];
			result.feed_value    <= vals_n[4];
		end
	end

	assign result.valid = res_valid_q;

	// a new result only follows a line-end word that moved into the core
	a_rise_from_eol: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(advance && item_s1.end_of_line))
		else $error("result raised without a line-end step");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready && valid_s1 && item_s1.end_of_line) |-> !advance)
		else $error("line-end step while result pending");

	// input only stalls with a word held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> valid_s1)
		else $error("input stalled with empty register");

endmodule

`default_nettype wire

// File: sv/glp_in_stage.sv
// ----------------------------------------------------------------------------
// glp_in_stage: input register
// Holds one character word; refills in the same cycle the held word moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module glp_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	glp_char_if.sink           chars,
	input  wire logic          take,
	output logic               valid_s1,
	output glp_pkg::item_t     item_s1
);

	assign chars.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1.char_byte   <= chars.char_byte;
			item_s1.end_of_line <= chars.end_of_line;
		end
	end

endmodule

`default_nettype wire

// File: sv/glp_core.sv
// ----------------------------------------------------------------------------
// glp_core: tokenizer, command matcher and decimal accumulator
// Updates the line state for one character per step and presents the stored
// code and values as they stand after that character.
// ----------------------------------------------------------------------------
`default_nettype none

module glp_core #(
	parameter int VALUE_WIDTH = glp_pkg::VALUE_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire glp_pkg::item_t                 item,
	output logic [2:0]                          code_n,
	output logic                                cmd_valid_n,
	output logic [VALUE_WIDTH-1:0]              vals_n [glp_pkg::NUM_VALUES]
);

	// sum width: CAP*10 plus the largest digit term
	localparam int SW = VALUE_WIDTH + 24;
	localparam logic [SW-1:0] CAP = SW'(1) << (VALUE_WIDTH - 1);
	localparam logic [2:0] FD = 3'(glp_pkg::FRACTION_DIGITS);

	logic                   in_token_q, first_q, rej_q;
	logic [2:0]             match_q, target_q, fc_q, code_q;
	glp_pkg::phase_t        phase_q;
	logic                   neg_q;
	// magnitude already scaled to thousandths (or the chosen scale), capped at CAP
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] vals_q [glp_pkg::NUM_VALUES];

	logic                   in_token_m, first_m, rej_m, neg_m;
	logic [2:0]             match_m, target_m, fc_m;
	glp_pkg::phase_t        phase_m;
	logic [VALUE_WIDTH-1:0] acc_m;

	logic [7:0]             c;
	logic                   is_sep, is_digit, do_fin;
	logic [3:0]             dig;
	logic [2:0]             fexp;
	logic [23:0]            dterm;
	logic [SW-1:0]          sum;
	logic [VALUE_WIDTH-1:0] clamped;

	assign c        = item.char_byte;
	assign is_sep   = (c == glp_pkg::CH_SPACE) || (c == glp_pkg::CH_CR) || (c == glp_pkg::CH_LF);
	assign is_digit = (c >= glp_pkg::CH_0) && (c <= glp_pkg::CH_9);
	assign dig      = 4'(c - glp_pkg::CH_0);

	// integer digits add d*10^F after *10, fraction digits add d*10^(F-1-fc)
	always_comb begin
		if (phase_q == glp_pkg::PH_FRAC && fc_q < FD) begin
			fexp = 3'(FD - fc_q - 3'd1);
		end else begin
			fexp = FD;
		end
		dterm = 24'(dig) * 24'(glp_pkg::pow10(fexp));
		if (phase_q == glp_pkg::PH_FRAC) begin
			sum = SW'(acc_q) + SW'(dterm);
		end else begin
			sum = (SW'(acc_q) << 3) + (SW'(acc_q) << 1) + SW'(dterm);
		end
	end

	always_comb begin
		in_token_m = in_token_q;
		first_m    = first_q;
		rej_m      = rej_q;
		match_m    = match_q;
		target_m   = target_q;
		acc_m      = acc_q;
		phase_m    = phase_q;
		neg_m      = neg_q;
		fc_m       = fc_q;
		do_fin     = 1'b0;

		if (!rej_q) begin
			if (is_sep) begin
				do_fin = in_token_q;
			end else if (in_token_q) begin
				if (first_q) begin
					if (match_q == glp_pkg::MATCH_G && c >= glp_pkg::CH_0 && c <= glp_pkg::CH_4) begin
						match_m = 3'(c - glp_pkg::CH_0);
					end else begin
						match_m = glp_pkg::MATCH_BAD;
					end
				end else if (target_q != glp_pkg::TGT_NONE && phase_q != glp_pkg::PH_STOP) begin
					if (phase_q == glp_pkg::PH_START &&
							(c == glp_pkg::CH_PLUS || c == glp_pkg::CH_MINUS)) begin
						phase_m = glp_pkg::PH_INT;
						neg_m   = (c == glp_pkg::CH_MINUS);
					end else if (is_digit && phase_q != glp_pkg::PH_FRAC) begin
						acc_m   = (sum > CAP) ? CAP[VALUE_WIDTH-1:0] : sum[VALUE_WIDTH-1:0];
						phase_m = glp_pkg::PH_INT;
					end else if (c == glp_pkg::CH_DOT && phase_q != glp_pkg::PH_FRAC) begin
						phase_m = glp_pkg::PH_FRAC;
					end else if (is_digit) begin
						if (fc_q < FD) begin
							acc_m = (sum > CAP) ? CAP[VALUE_WIDTH-1:0] : sum[VALUE_WIDTH-1:0];
							fc_m  = fc_q + 3'd1;
						end
					end else begin
						phase_m = glp_pkg::PH_STOP;
					end
				end
			end else begin
				// token start
				if (first_q) begin
					if (c != glp_pkg::CH_G) begin
						rej_m   = 1'b1;
						first_m = 1'b0;
					end else begin
						match_m    = glp_pkg::MATCH_G;
						in_token_m = 1'b1;
					end
				end else begin
					case (c)
						glp_pkg::CH_X: target_m = glp_pkg::TGT_X;
						glp_pkg::CH_Y: target_m = glp_pkg::TGT_Y;
						glp_pkg::CH_Z: target_m = glp_pkg::TGT_Z;
						glp_pkg::CH_E: target_m = glp_pkg::TGT_E;
						glp_pkg::CH_F: target_m = glp_pkg::TGT_F;
						default:       target_m = glp_pkg::TGT_NONE;
					endcase
					acc_m      = '0;
					phase_m    = glp_pkg::PH_START;
					neg_m      = 1'b0;
					fc_m       = 3'd0;
					in_token_m = 1'b1;
				end
			end
			// line end closes an open token too
			if (item.end_of_line && !is_sep && in_token_m) begin
				do_fin = 1'b1;
			end
		end
	end

	// saturate to the signed range; acc never exceeds CAP
	always_comb begin
		if (neg_m) begin
			clamped = VALUE_WIDTH'(0) - acc_m;
		end else if (acc_m[VALUE_WIDTH-1]) begin
			clamped = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end else begin
			clamped = acc_m;
		end
	end

	always_comb begin
		code_n = code_q;
		for (int i = 0; i < glp_pkg::NUM_VALUES; i++) begin
			vals_n[i] = vals_q[i];
		end
		if (do_fin && first_m) begin
			code_n = (match_m <= 3'd4) ? match_m : glp_pkg::MATCH_BAD;
		end else if (do_fin) begin
			for (int i = 0; i < glp_pkg::NUM_VALUES; i++) begin
				if (target_m == 3'(i + 1)) begin
					vals_n[i] = clamped;
				end
			end
		end
		cmd_valid_n = !rej_m && !(first_m && !do_fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_token_q <= 1'b0;
			first_q    <= 1'b1;
			rej_q      <= 1'b0;
			match_q    <= 3'd0;
			target_q   <= glp_pkg::TGT_NONE;
			acc_q      <= '0;
			phase_q    <= glp_pkg::PH_START;
			neg_q      <= 1'b0;
			fc_q       <= 3'd0;
			code_q     <= glp_pkg::MATCH_BAD;
			for (int i = 0; i < glp_pkg::NUM_VALUES; i++) begin
				vals_q[i] <= '0;
			end
		end else if (step) begin
			code_q <= code_n;
			for (int i = 0; i < glp_pkg::NUM_VALUES; i++) begin
				vals_q[i] <= vals_n[i];
			end
			if (item.end_of_line) begin
				in_token_q <= 1'b0;
				first_q    <= 1'b1;
				rej_q      <= 1'b0;
				match_q    <= 3'd0;
				target_q   <= glp_pkg::TGT_NONE;
				acc_q      <= '0;
				phase_q    <= glp_pkg::PH_START;
				neg_q      <= 1'b0;
				fc_q       <= 3'd0;
			end else begin
				in_token_q <= do_fin ? 1'b0 : in_token_m;
				first_q    <= do_fin ? 1'b0 : first_m;
				rej_q      <= rej_m;
				match_q    <= match_m;
				target_q   <= do_fin ? glp_pkg::TGT_NONE : target_m;
				acc_q      <= acc_m;
				phase_q    <= phase_m;
				neg_q      <= neg_m;
				fc_q       <= fc_m;
			end
		end
	end

endmodule

`default_nettype wire
